// ----- rtl/ppw_pkg.sv -----
// Package for the particle push block: types, opcodes, wall modes and limits.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ppw_pkg;
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_PUSH   = 2'd1;
  localparam logic [1:0] FUNC_REWIND = 2'd2;
  localparam logic [1:0] FUNC_REPORT = 2'd3;

  localparam logic [1:0] WALL_ABSORB  = 2'd0;
  localparam logic [1:0] WALL_REFLECT = 2'd1;
  localparam logic [1:0] WALL_WRAP    = 2'd2;

  localparam logic [2:0] REG_LEFT_MODE  = 3'd0;
  localparam logic [2:0] REG_RIGHT_MODE = 3'd1;
  localparam logic [2:0] REG_CELLS      = 3'd2;
  localparam logic [2:0] REG_ACCEL      = 3'd3;
  localparam logic [2:0] REG_DRIFT      = 3'd4;

  localparam logic [62:0] E_MAX   = {63{1'b1}};
  localparam logic [47:0] MOM_MAX = {1'b0, {47{1'b1}}};
  localparam logic [47:0] MOM_MIN = {1'b1, {47{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH, ST_INTERP, ST_KICK, ST_DRIFT, ST_WALL, ST_ABSORB,
    ST_EMIT, ST_REP0, ST_REP1
  } state_t;

  typedef struct packed {
    logic load;      // capture input word
    logic node_wr;   // write field store
    logic interp;
    logic kick;
    logic drift;
    logic wall;
    logic absorb;
    logic emit_part;
    logic emit_rep;
    logic rep_side;
  } cmd_t;

  typedef struct packed {
    logic absorbed;
    logic out_busy;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -49'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ----- rtl/ppw_if.sv -----
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; payload width set per instance.
`timescale 1ns / 1ps
`default_nettype none
interface ppw_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/particle_push_with_walls_core.sv -----
// Top level of the 1D particle push block: controller, datapath, config registers.
// Uses ppw_pkg, ppw_if, ppw_ctrl, ppw_datapath.
`timescale 1ns / 1ps
`default_nettype none
// One word at a time. A field write completes in the accepting cycle; a push
// or rewind steps through the accepting cycle, field store read, interpolation,
// kick multiply, drift multiply, wall step, and emit or absorb, and may stall
// on the output; a report emits two words, each of which may stall. The chain of
// dependent multiplies through the controller sets this sequence.
// Field nodes never written read as unknown. Results are word-packed
// {kind,new_position,new_vel_x,out_vel_y,out_vel_z,side,lost_count,
// energy_sum,momentum_sum,last}; input {func,node_index,field_value,position,
// vel_x,vel_y,vel_z}.
module particle_push_with_walls_core #(
  parameter int MAX_CELLS = 1024
) (
  input  wire        clk,
  input  wire        rst_n,
  ppw_if.sink        in_ch,
  ppw_if.source      out_ch,
  input  wire        cfg_we,
  input  wire [2:0]  cfg_index,
  input  wire [31:0] cfg_data
);
  import ppw_pkg::*;
  logic [1:0] left_r, right_r;
  logic [10:0] cells_r;
  logic signed [31:0] accel_r, drift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= WALL_ABSORB; right_r <= WALL_ABSORB; cells_r <= 11'd1024;
      accel_r <= '0; drift_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_MODE:  left_r <= cfg_data[1:0];
        REG_RIGHT_MODE: right_r <= cfg_data[1:0];
        REG_CELLS:      cells_r <= cfg_data[10:0];
        REG_ACCEL:      accel_r <= cfg_data;
        REG_DRIFT:      drift_r <= cfg_data;
        default: ;
      endcase
    end
  end

  cmd_t cmd;
  stat_t stat;
  logic ready;

  ppw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_func(in_ch.data[166:165]),
    .in_ready(ready), .stat(stat), .cmd(cmd)
  );
  assign in_ch.ready = ready;

  ppw_datapath #(.MAX_CELLS(MAX_CELLS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .left_mode(left_r), .right_mode(right_r), .cell_count(cells_r),
    .accel(accel_r), .drift(drift_r),
    .func(in_ch.data[166:165]), .node_index(in_ch.data[164:154]),
    .field_value(in_ch.data[153:122]), .position(in_ch.data[121:96]),
    .vel_x(in_ch.data[95:64]), .vel_y(in_ch.data[63:32]), .vel_z(in_ch.data[31:0]),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_word(out_ch.data)
  );

  // field writes complete in the accepting cycle, so only other words block
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && !cmd.node_wr |=> !cmd.load) else $error("word taken while busy");
  a_emit_one: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_part && cmd.emit_rep)) else $error("two results at once");
  a_absorb_silent: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.absorb |-> !cmd.emit_part) else $error("absorbed particle emitted");
endmodule
`default_nettype wire

// ----- rtl/ppw_ctrl.sv -----
// Controller state machine for the particle push block.
// Uses ppw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ppw_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire [1:0]            in_func,
  output logic                 in_ready,
  input  wire ppw_pkg::stat_t  stat,
  output ppw_pkg::cmd_t        cmd
);
  import ppw_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FUNC_WRITE:  state_nxt = ST_IDLE;
            FUNC_REPORT: state_nxt = ST_REP0;
            default:     state_nxt = ST_FETCH;
          endcase
        end
      end
      ST_FETCH:  state_nxt = ST_INTERP;
      ST_INTERP: state_nxt = ST_KICK;
      ST_KICK:   state_nxt = ST_DRIFT;
      ST_DRIFT:  state_nxt = ST_WALL;
      ST_WALL:   state_nxt = stat.absorbed ? ST_ABSORB : ST_EMIT;
      ST_ABSORB: state_nxt = ST_IDLE;
      ST_EMIT:   if (!stat.out_busy) state_nxt = ST_IDLE;
      ST_REP0:   if (!stat.out_busy) state_nxt = ST_REP1;
      ST_REP1:   if (!stat.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        cmd.node_wr = in_valid && (in_func == FUNC_WRITE);
      end
      ST_INTERP: cmd.interp = 1'b1;
      ST_KICK:   cmd.kick = 1'b1;
      ST_DRIFT:  cmd.drift = 1'b1;
      ST_WALL:   cmd.wall = 1'b1;
      ST_ABSORB: cmd.absorb = 1'b1;
      ST_EMIT:   cmd.emit_part = !stat.out_busy;
      ST_REP0:   cmd.emit_rep = !stat.out_busy;
      ST_REP1: begin
        cmd.emit_rep = !stat.out_busy;
        cmd.rep_side = 1'b1;
      end
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/ppw_datapath.sv -----
// Datapath: field store, interpolation, kick, drift, walls, wall totals, output register.
// Uses ppw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ppw_datapath #(
  parameter int MAX_CELLS = 1024
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire ppw_pkg::cmd_t   cmd,
  output ppw_pkg::stat_t       stat,
  input  wire [1:0]            left_mode,
  input  wire [1:0]            right_mode,
  input  wire [10:0]           cell_count,
  input  wire signed [31:0]    accel,
  input  wire signed [31:0]    drift,
  input  wire [1:0]            func,
  input  wire [10:0]           node_index,
  input  wire signed [31:0]    field_value,
  input  wire [25:0]           position,
  input  wire signed [31:0]    vel_x,
  input  wire signed [31:0]    vel_y,
  input  wire signed [31:0]    vel_z,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [267:0]         out_word
);
  import ppw_pkg::*;
  localparam int AW = $clog2(MAX_CELLS + 1);

  logic [31:0] mem [0:MAX_CELLS];
  logic signed [31:0] f0_r, f1_r;
  logic [1:0]  func_r;
  logic [25:0] pos_r;
  logic signed [31:0] vx_r, vy_r, vz_r;
  logic signed [31:0] e_r;
  logic signed [48:0] xi_r;
  logic side_r;
  logic [31:0] lost_r [2];
  logic [62:0] en_r [2];
  logic signed [47:0] mom_r [2];
  logic ov_r;
  logic [267:0] ow_r;

  // clamped cell count and domain end
  logic [16:0] cc;
  always_comb begin
    cc = {6'd0, cell_count};
    if (cell_count < 11'd2) cc = 17'd2;
    if ({6'd0, cell_count} > 17'(MAX_CELLS)) cc = 17'(MAX_CELLS);
  end
  logic [16:0] lidx;
  logic beyond;
  assign lidx   = {7'd0, pos_r[25:16]};
  assign beyond = {7'd0, pos_r[25:16]} >= cc;
  logic [AW-1:0] ra0, ra1;
  assign ra0 = beyond ? cc[AW-1:0] : lidx[AW-1:0];
  assign ra1 = beyond ? cc[AW-1:0] : AW'(lidx + 17'd1);

  always_ff @(posedge clk) begin
    if (cmd.node_wr && ({6'd0, node_index} <= 17'(MAX_CELLS)))
      mem[node_index[AW-1:0]] <= field_value;
    f0_r <= mem[ra0];
    f1_r <= mem[ra1];
  end

  // interpolation: full precision product sum, >>16 floor
  logic [16:0] d, dn;
  logic signed [50:0] isum;
  assign d    = {1'b0, pos_r[15:0]};
  assign dn   = 17'd65536 - d;
  assign isum = beyond ? 51'(f0_r) <<< 16
              : 51'(f0_r * $signed({1'b0, dn})) + 51'(f1_r * $signed({1'b0, d}));

  logic signed [63:0] kprod, dprod;
  assign kprod = 64'(accel) * 64'(e_r);
  assign dprod = 64'(vx_r) * 64'(drift);
  // kick and drift deltas reach 47 bits before saturation or wall handling
  logic signed [48:0] kv;
  assign kv = (func_r == FUNC_REWIND) ? 49'(vx_r) - 49'(kprod >>> 17)
                                      : 49'(vx_r) + 49'(kprod >>> 16);

  logic signed [48:0] w;
  assign w = $signed({16'd0, cc, 16'd0});
  logic lo, hi;
  logic [1:0] md;
  assign lo = xi_r < 0;
  assign hi = xi_r > w;
  assign md = lo ? left_mode : right_mode;
  logic signed [49:0] xw;
  always_comb begin
    xw = 50'(xi_r);
    if (md == WALL_REFLECT) xw = lo ? -50'(xi_r) : 50'(2 * w) - 50'(xi_r);
    else if (md == WALL_WRAP) xw = lo ? 50'(xi_r) + 50'(w) : 50'(xi_r) - 50'(w);
    if (xw < 0) xw = '0;
    if (xw > 50'(w)) xw = 50'(w);
  end
  assign stat.absorbed = (func_r != FUNC_REWIND) && (lo || hi) &&
                         (md != WALL_REFLECT) && (md != WALL_WRAP);
  assign stat.out_busy = ov_r && !out_ready;

  // absorb energy terms
  logic [63:0] sx2, sy2, sz2;
  logic [64:0] es;
  logic [62:0] ea, etot;
  logic [63:0] ew;
  logic signed [48:0] mn;
  assign sx2 = 64'(vx_r * vx_r);
  assign sy2 = 64'(vy_r * vy_r);
  assign sz2 = 64'(vz_r * vz_r);
  always_comb begin
    es = 65'(sx2) + 65'(sy2);
    ea = (es > 65'(E_MAX)) ? E_MAX : es[62:0];
    es = 65'(ea) + 65'(sz2);
    ea = (es > 65'(E_MAX)) ? E_MAX : es[62:0];
    ew = 64'(en_r[side_r]) + 64'(ea);
    etot = ew[63] ? E_MAX : ew[62:0];
    mn = 49'(mom_r[side_r]) + 49'(vx_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func; pos_r <= position;
      vx_r <= vel_x; vy_r <= vel_y; vz_r <= vel_z;
    end
    if (cmd.interp) e_r <= 32'(isum >>> 16);
    if (cmd.kick) vx_r <= sat32(kv);
    if (cmd.drift) xi_r <= 49'(pos_r) + 49'(dprod >>> 16);
    if (cmd.wall) begin
      side_r <= hi;
      if (func_r == FUNC_REWIND) xi_r <= 49'(pos_r);
      else if ((lo || hi) && !stat.absorbed) begin
        xi_r <= 49'(xw);
        if (md == WALL_REFLECT) vx_r <= sat32(-49'(vx_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        lost_r[i] <= '0; en_r[i] <= '0; mom_r[i] <= '0;
      end
      ov_r <= 1'b0;
    end else begin
      if (cmd.absorb) begin
        if (lost_r[side_r] != '1) lost_r[side_r] <= lost_r[side_r] + 32'd1;
        en_r[side_r] <= etot;
        if (mn > $signed(49'(MOM_MAX))) mom_r[side_r] <= MOM_MAX;
        else if (mn < 49'($signed(MOM_MIN))) mom_r[side_r] <= MOM_MIN;
        else mom_r[side_r] <= mn[47:0];
      end
      if (cmd.emit_rep) begin
        lost_r[cmd.rep_side] <= '0; en_r[cmd.rep_side] <= '0;
        mom_r[cmd.rep_side] <= '0;
      end
      if (cmd.emit_part || cmd.emit_rep) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // word: kind,pos,vx,vy,vz,side,lost,energy,mom,last
  always_ff @(posedge clk) begin
    if (cmd.emit_part)
      ow_r <= {1'b0, (xi_r > 49'sh3FFFFFF) ? 26'h3FFFFFF : xi_r[25:0], vx_r, vy_r, vz_r,
               1'b0, 32'd0, 63'd0, 48'd0, 1'b1};
    else if (cmd.emit_rep)
      ow_r <= {1'b1, 26'd0, 96'd0, cmd.rep_side, lost_r[cmd.rep_side],
               en_r[cmd.rep_side], mom_r[cmd.rep_side], cmd.rep_side};
  end
  assign out_valid = ov_r;
  assign out_word  = ow_r;
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for particle_push_with_walls_core: random and directed words,
// a scoreboard class that predicts every result. Depends on ppw_pkg, ppw_if and the RTL.
`timescale 1ns / 1ps
module tb_top;
  import ppw_pkg::*;

  localparam int NODE_LAST = 1024;
  localparam int NODE_INIT = 65;
  localparam int POS_LIM = 64 << 16;
  localparam int POS_SPAN = 1 << 26;
  localparam int LIMIT = 600000;
  localparam logic [25:0] POS_TOP = 26'h3FFFFFF;

  typedef struct packed {
    logic [1:0]         func;
    logic [10:0]        node_index;
    logic signed [31:0] field_value;
    logic [25:0]        position;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } push_word_t;

  typedef struct packed {
    logic               kind;
    logic [25:0]        new_position;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic               side;
    logic [31:0]        lost_count;
    logic [62:0]        energy_sum;
    logic signed [47:0] momentum_sum;
    logic               last;
  } result_t;

  class push_scoreboard;
    logic signed [31:0] field_nodes[0:NODE_LAST];
    logic [31:0] lost[2];
    longint unsigned energy[2];
    longint mom[2];
    logic [1:0] left_mode, right_mode;
    logic [10:0] cell_reg;
    longint accel, drift;
    result_t expected_results[$];
    int fails;

    function new();
      for (int i = 0; i <= NODE_LAST; i++) field_nodes[i] = '0;
      for (int s = 0; s < 2; s++) begin
        lost[s] = 0; energy[s] = 0; mom[s] = 0;
      end
      left_mode = WALL_ABSORB; right_mode = WALL_ABSORB;
      cell_reg = 11'd1024; accel = 0; drift = 0; fails = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_LEFT_MODE:  left_mode = val[1:0];
        REG_RIGHT_MODE: right_mode = val[1:0];
        REG_CELLS:      cell_reg = val[10:0];
        REG_ACCEL:      accel = longint'($signed(val));
        REG_DRIFT:      drift = longint'($signed(val));
        default: ;
      endcase
    endfunction

    function longint cells();
      if (cell_reg < 2) return 2;
      if (cell_reg > NODE_LAST) return NODE_LAST;
      return longint'(cell_reg);
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint field_at(logic [25:0] pos);
      longint l, d;
      l = longint'(pos[25:16]);
      d = longint'(pos[15:0]);
      if (l >= cells()) return longint'(field_nodes[cells()]);
      return (longint'(field_nodes[l]) * (65536 - d) + longint'(field_nodes[l + 1]) * d) >>> 16;
    endfunction

    function void absorb(int s, longint vx, longint vy, longint vz);
      longint unsigned e, t;
      longint m;
      e = vx * vx;
      t = vy * vy;
      e = (e + t > E_MAX) ? E_MAX : e + t;
      t = vz * vz;
      e = (e + t > E_MAX) ? E_MAX : e + t;
      energy[s] = (energy[s] > E_MAX - e) ? E_MAX : energy[s] + e;
      if (lost[s] != 32'hFFFFFFFF) lost[s]++;
      m = mom[s] + vx;
      if (m > 64'sd140737488355327) m = 64'sd140737488355327;
      if (m < -64'sd140737488355328) m = -64'sd140737488355328;
      mom[s] = m;
    endfunction

    function void emit_particle(longint pos, longint vx, push_word_t w);
      result_t r;
      r = '0;
      r.new_position = (pos > longint'(POS_TOP)) ? POS_TOP : pos[25:0];
      r.new_vel_x = vx[31:0];
      r.out_vel_y = w.vel_y;
      r.out_vel_z = w.vel_z;
      r.last = 1'b1;
      expected_results.push_back(r);
    endfunction

    function void note_word(push_word_t w);
      longint e, vx, xi, span;
      logic [1:0] mode;
      int s;
      result_t r;
      case (w.func)
        FUNC_WRITE: if (w.node_index <= NODE_LAST) field_nodes[w.node_index] = w.field_value;
        FUNC_REPORT: begin
          for (s = 0; s < 2; s++) begin
            r = '0;
            r.kind = 1'b1;
            r.side = s[0];
            r.lost_count = lost[s];
            r.energy_sum = energy[s][62:0];
            r.momentum_sum = mom[s][47:0];
            r.last = s[0];
            expected_results.push_back(r);
            lost[s] = 0; energy[s] = 0; mom[s] = 0;
          end
        end
        FUNC_REWIND: begin
          e = field_at(w.position);
          vx = sat32(longint'(w.vel_x) - ((accel * e) >>> 17));
          emit_particle(longint'(w.position), vx, w);
        end
        default: begin
          e = field_at(w.position);
          vx = sat32(longint'(w.vel_x) + ((accel * e) >>> 16));
          xi = longint'(w.position) + ((vx * drift) >>> 16);
          span = cells() * 65536;
          if (xi < 0 || xi > span) begin
            s = (xi < 0) ? 0 : 1;
            mode = s ? right_mode : left_mode;
            if (mode == WALL_REFLECT) begin
              xi = s ? 2 * span - xi : -xi;
              vx = sat32(-vx);
            end else if (mode == WALL_WRAP) begin
              xi = s ? xi - span : xi + span;
            end else begin
              absorb(s, vx, longint'(w.vel_y), longint'(w.vel_z));
              return;
            end
            if (xi < 0) xi = 0;
            if (xi > span) xi = span;
          end
          emit_particle(xi, vx, w);
        end
      endcase
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %h, got %h", name, exp_v, act_v);
        fails++;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result word %h", got);
        fails++;
        return;
      end
      want = expected_results.pop_front();
      cmp("kind", want.kind, got.kind);
      cmp("new_position", want.new_position, got.new_position);
      cmp("new_vel_x", want.new_vel_x, got.new_vel_x);
      cmp("out_vel_y", want.out_vel_y, got.out_vel_y);
      cmp("out_vel_z", want.out_vel_z, got.out_vel_z);
      cmp("side", want.side, got.side);
      cmp("lost_count", want.lost_count, got.lost_count);
      cmp("energy_sum", want.energy_sum, got.energy_sum);
      cmp("momentum_sum", want.momentum_sum, got.momentum_sum);
      cmp("last", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_LEFT_MODE;
  logic [31:0] cfg_data = '0;
  logic calm = 1'b0;
  int cycles = 0;
  int span_now;
  push_scoreboard sb = new();

  ppw_if #(.W($bits(push_word_t))) in_ch ();
  ppw_if #(.W($bits(result_t))) out_ch ();

  particle_push_with_walls_core #(.MAX_CELLS(NODE_LAST)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_word(out_ch.data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL particle_push_with_walls_core");
      $finish;
    end
  end

  task automatic send_word(input push_word_t w);
    while (!calm && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(w);
  endtask

  // drain: no word in flight, then room for an absorbed push to finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic setup(input logic [1:0] lm, input logic [1:0] rm, input logic [10:0] nc,
                       input logic [31:0] acc, input logic [31:0] dft);
    write_reg(REG_LEFT_MODE, {30'd0, lm});
    write_reg(REG_RIGHT_MODE, {30'd0, rm});
    write_reg(REG_CELLS, {21'd0, nc});
    write_reg(REG_ACCEL, acc);
    write_reg(REG_DRIFT, dft);
    cfg_we <= 1'b0;
    span_now = int'(sb.cells()) * 65536;
  endtask

  function automatic logic [31:0] rand_field();
    if ($urandom_range(9) < 2) return $urandom;
    return $urandom_range(1 << 18) - (1 << 17);
  endfunction

  function automatic push_word_t particle(input logic [1:0] f, input logic [25:0] pos,
                                          input logic [31:0] vx);
    push_word_t w;
    w.func = f;
    w.node_index = 11'($urandom_range(2047));
    w.field_value = $urandom;
    w.position = pos;
    w.vel_x = vx;
    w.vel_y = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 20) - (1 << 19);
    w.vel_z = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 20) - (1 << 19);
    return w;
  endfunction

  function automatic push_word_t rand_word();
    push_word_t w;
    int pick;
    int lim;
    logic [25:0] pos;
    logic [31:0] vx;
    pick = $urandom_range(99);
    // inside the domain, positions stay over the preloaded nodes
    lim = (span_now > POS_LIM) ? POS_LIM : span_now;
    case ($urandom_range(19))
      0: pos = '0;
      1: pos = (span_now < POS_SPAN) ? 26'(span_now) : 26'(lim);
      2: pos = (span_now < POS_SPAN) ? 26'($urandom_range(POS_TOP, span_now)) : 26'(lim);
      default: pos = 26'($urandom_range(lim));
    endcase
    vx = ($urandom_range(6) == 0) ? $urandom : $urandom_range(3 * span_now) - 3 * span_now / 2;
    if (pick < 12) begin
      w = particle(FUNC_WRITE, pos, vx);
      w.node_index = ($urandom_range(9) == 0) ? 11'($urandom_range(2047))
                                              : 11'($urandom_range(NODE_LAST));
      w.field_value = rand_field();
    end else if (pick < 18) w = particle(FUNC_REPORT, pos, vx);
    else if (pick < 32) w = particle(FUNC_REWIND, pos, vx);
    else w = particle(FUNC_PUSH, pos, vx);
    return w;
  endfunction

  initial begin
    logic [1:0] lm;
    logic [10:0] nc;
    logic [31:0] acc, dft;
    push_word_t w;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // every node a push can read gets a value first: the low nodes and the last
    for (int i = 0; i <= NODE_INIT + 1; i++) begin
      w = particle(FUNC_WRITE, 0, 0);
      w.node_index = (i > NODE_INIT) ? 11'(NODE_LAST) : 11'(i);
      w.field_value = rand_field();
      send_word(w);
    end
    settle();
    setup(WALL_ABSORB, WALL_REFLECT, 11'd4, 32'h0001_0000, 32'h0001_0000);
    span_now = 4 * 65536;
    send_word(particle(FUNC_PUSH, 26'd0, 32'd0));
    send_word(particle(FUNC_PUSH, 26'd4 << 16, 32'd0));
    send_word(particle(FUNC_PUSH, POS_TOP, 32'd0));
    send_word(particle(FUNC_PUSH, 26'd1 << 16, -32'sd500000));
    send_word(particle(FUNC_PUSH, 26'd3 << 16, 32'sd500000));
    send_word(particle(FUNC_PUSH, 26'd2 << 16, 32'h7FFFFFFF));
    send_word(particle(FUNC_PUSH, 26'd2 << 16, 32'h80000000));
    send_word(particle(FUNC_REWIND, 26'h1_8000, 32'h80000000));
    send_word(particle(FUNC_REWIND, POS_TOP, 32'h7FFFFFFF));
    w = particle(FUNC_WRITE, 0, 0);
    w.node_index = 11'd1025; send_word(w);
    w.node_index = 11'd2047; send_word(w);
    w.node_index = 11'd1024; w.field_value = 32'h7FFFFFFF; send_word(w);
    w = particle(FUNC_PUSH, 26'd1, -32'sd1000000);
    w.vel_y = 32'h80000000; w.vel_z = 32'h7FFFFFFF; send_word(w);
    send_word(particle(FUNC_REPORT, 0, 0));
    send_word(particle(FUNC_REPORT, 0, 0));
    settle();
    for (int ph = 0; ph < 8; ph++) begin
      lm = 2'(ph % 4);
      case (ph)
        0: nc = 11'd0;
        1: nc = 11'd2;
        2: nc = 11'd2047;
        3: nc = 11'd1024;
        default: nc = 11'($urandom_range(3, 40));
      endcase
      case (ph)
        4: begin acc = 32'h7FFFFFFF; dft = 32'h80000000; end
        5: begin acc = 32'h80000000; dft = 32'h7FFFFFFF; end
        6: begin acc = 32'hFFFF8000; dft = 32'h0000_4000; end
        default: begin acc = $urandom_range(1 << 18) - (1 << 17); dft = 32'h0001_0000; end
      endcase
      setup(lm, 2'((ph + 1) % 4), nc, acc, dft);
      calm = (ph == 3);
      for (int k = 0; k < 125; k++) send_word(rand_word());
      send_word(particle(FUNC_REPORT, 0, 0));
      settle();
    end
    calm = 1'b0;
    if (sb.fails == 0) $display("PASS particle_push_with_walls_core");
    else $display("FAIL particle_push_with_walls_core");
    $finish;
  end
endmodule
